// ===== hdl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths and types of the TLB and page-table translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

   localparam int ADDR_W  = 16;
   localparam int FRAME_W = 8;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlbpt_lookup_type;

endpackage

`default_nettype wire

// ===== hdl/tlbpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB: parallel tag match with the lowest matching entry
// winning, and fill at a FIFO pointer that advances on every fill.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_tlb
   import tlbpt_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int PAGE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [PAGE_BITS-1:0] look_page,
   output tlbpt_lookup_type          look_result,
   input  wire logic                 fill_en,
   input  wire logic [PAGE_BITS-1:0] fill_page,
   input  wire logic [FRAME_W-1:0]   fill_frame
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   valid_in;
   logic [PAGE_BITS-1:0] tag_ff   [ENTRIES];
   logic [FRAME_W-1:0]   frame_ff [ENTRIES];
   logic [IDX_W-1:0]     ptr_ff;
   logic [IDX_W-1:0]     ptr_in;

   // lowest matching entry wins
   always_comb begin
      look_result = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == look_page)) begin
            look_result.hit   = 1'b1;
            look_result.frame = frame_ff[i];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (fill_en) begin
         valid_in[ptr_ff] = 1'b1;
         if (ptr_ff == IDX_W'(ENTRIES - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         tag_ff[ptr_ff]   <= fill_page;
         frame_ff[ptr_ff] <= fill_frame;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation with a TLB and demand paging.
// ----------------------------------------------------------------------------
// Each translation runs through the transfer cycle and the lookup state: in
// the transfer cycle the page is matched against all TLB entries and the page
// table is read; in the lookup state the page-table data is used, a fault
// allocates the next free frame and writes the page table, and a miss refills
// the TLB entry at the FIFO pointer. A result waits in an output register
// while the next request is taken. After reset the page table is cleared one
// entry per cycle, all PAGE_COUNT entries, with req_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ADDR_W-1:0] req_logical_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [ADDR_W-1:0]      rsp_phys_addr,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault
);

   localparam int PAGE_BITS = $clog2(PAGE_COUNT);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP
   } state_type;

   state_type              state_ff, state_in;
   logic [PAGE_BITS-1:0]   clr_ff, clr_in;
   logic [FRAME_W-1:0]     free_ff, free_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   tlbpt_lookup_type       look_ff, look_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_phys_ff, rsp_phys_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_fault_ff, rsp_fault_in;

   logic [FRAME_W:0]       pt_mem [PAGE_COUNT];
   logic [FRAME_W:0]       pt_rd_ff;
   logic                   pt_we;
   logic [PAGE_BITS-1:0]   pt_waddr;
   logic [FRAME_W:0]       pt_wdata;

   logic                   req_xfer;
   logic                   done;
   logic                   fault;
   logic [FRAME_W-1:0]     frame;
   logic [ADDR_W-1:0]      vpn;
   logic [PAGE_BITS-1:0]   req_page;
   tlbpt_lookup_type       look_result;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign vpn       = req_logical_address >> OFFSET_BITS;
   assign req_page  = PAGE_BITS'(vpn);

   assign done  = (state_ff == S_LOOKUP) && (!rsp_valid_ff || !rsp_stall);
   assign fault = !look_ff.hit && !pt_rd_ff[FRAME_W];
   assign frame = look_ff.hit ? look_ff.frame :
                  (fault ? free_ff : pt_rd_ff[FRAME_W-1:0]);

   tlbpt_tlb #(
      .ENTRIES   (TLB_ENTRIES),
      .PAGE_BITS (PAGE_BITS)
   ) u_tlb (
      .clock       (clock),
      .reset       (reset),
      .look_page   (req_page),
      .look_result (look_result),
      .fill_en     (done && !look_ff.hit),
      .fill_page   (page_ff),
      .fill_frame  (frame)
   );

   // page table: mapped flag above the frame
   always_comb begin
      pt_we    = 1'b0;
      pt_waddr = page_ff;
      pt_wdata = {1'b1, free_ff};
      if (state_ff == S_CLEAR) begin
         pt_we    = 1'b1;
         pt_waddr = clr_ff;
         pt_wdata = '0;
      end else if (done && fault) begin
         pt_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      if (req_xfer) begin
         pt_rd_ff <= pt_mem[req_page];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_in      = free_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      look_in      = look_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_phys_in  = rsp_phys_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fault_in = rsp_fault_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PAGE_BITS'(PAGE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               page_in   = req_page;
               offset_in = OFFSET_BITS'(req_logical_address);
               look_in   = look_result;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (done) begin
               rsp_valid_in = 1'b1;
               rsp_phys_in  = ADDR_W'({frame, offset_ff});
               rsp_hit_in   = look_ff.hit;
               rsp_fault_in = fault;
               if (fault) begin
                  free_in = free_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff      <= page_in;
      offset_ff    <= offset_in;
      look_ff      <= look_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_tlb_hit    = rsp_hit_ff;
   assign rsp_page_fault = rsp_fault_ff;

endmodule

`default_nettype wire
